// ===== rtl/iovq_pkg.sv =====
// shared types and constants of the interval overlap query block
`timescale 1ns / 1ps

package iovq_pkg;

  // default number of table cells
  localparam int DEPTH_DEF = 64;

  // input item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // result status codes
  localparam logic [2:0] ST_MATCH    = 3'd0;
  localparam logic [2:0] ST_NO_MATCH = 3'd1;
  localparam logic [2:0] ST_LOADED   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_SPAN        = 2'd0;
  localparam logic [1:0] CFG_NOT_SPAN    = 2'd1;
  localparam logic [1:0] CFG_NOT_SPANNED = 2'd2;

  // one stored interval, end kept at 33 bits
  typedef struct packed {
    logic [31:0] lo;
    logic [32:0] hi;
  } entry_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctl_t;

  // filter mode flags
  typedef struct packed {
    logic span;
    logic not_span;
    logic not_spanned;
  } mode_t;

endpackage

// ===== rtl/iovq_cell.sv =====
// one table cell: holds an interval, shifts on insertion, rotates during a query
`timescale 1ns / 1ps

module iovq_cell
  import iovq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  entry_t    new_entry,
  input  entry_t    prev_entry,
  input  logic      prev_g,
  input  entry_t    next_entry,
  output entry_t    entry,
  output logic      g
);

  // cell sits at or after the insertion point
  assign g = !occ || (entry.lo > new_entry.lo);

  // insertion takes the left neighbor or the new interval, rotation the right neighbor
  always_ff @(posedge clk) begin
    if (ctl.insert && g) begin
      entry <= prev_g ? prev_entry : new_entry;
    end else if (ctl.rotate) begin
      entry <= next_entry;
    end
  end

endmodule

// ===== rtl/iovq_match.sv =====
// overlap test and mode filters for the interval at the head of the chain
`timescale 1ns / 1ps

module iovq_match
  import iovq_pkg::*;
(
  input  entry_t      head,
  input  logic        head_valid,
  input  logic [31:0] q_lo,
  input  logic [32:0] q_hi,
  input  mode_t       mode,
  output logic        hit
);

  logic [32:0] s_lo;
  logic [32:0] q_lo_x;
  logic        overlap;
  logic        span;
  logic        spanned;

  assign s_lo   = {1'b0, head.lo};
  assign q_lo_x = {1'b0, q_lo};

  // half-open overlap and containment both ways
  assign overlap = (s_lo < q_hi) && (q_lo_x < head.hi);
  assign span    = (s_lo <= q_lo_x) && (q_hi <= head.hi);
  assign spanned = (q_lo_x <= s_lo) && (head.hi <= q_hi);

  // survivor after all enabled filters
  assign hit = head_valid && overlap
             && !(mode.span && !span)
             && !(mode.not_span && span)
             && !(mode.not_spanned && spanned);

endmodule

// ===== rtl/interval_overlap_query.sv =====
// top level: sorted interval table as a chain of cells with an overlap query sequencer
`timescale 1ns / 1ps

// Keeps up to DEPTH reference intervals in ascending start order, one per cell.
// A clear or a load gives one result; a load into a table that is not full
// places the new interval in all cells at once, each cell comparing its start
// and shifting right past the insertion point. A query rotates the whole chain
// by DEPTH positions, one per cycle unless a new match meets a waiting one on
// a stalled output, testing the interval at the head. Matches leave in start
// order, one transfer each, with last set on the final one; a query without
// survivors gives a single no-match result.

module interval_overlap_query
  import iovq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] start_req,
  input  logic [31:0] length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] match_start,
  output logic [32:0] match_end,
  output logic        last
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int STEP_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [STEP_W-1:0] step;
  mode_t             mode;
  logic [31:0]       q_lo;
  logic [32:0]       q_hi;
  logic              pend_valid;
  entry_t            pend;

  entry_t            new_entry;
  entry_t            cells [DEPTH];
  logic [DEPTH-1:0]  g;
  logic [DEPTH-1:0]  occ;
  cell_ctl_t         ctl;

  logic              in_xfer;
  logic              out_free;
  logic              head_valid;
  logic              hit;
  logic              adv;
  logic              full;
  logic              out_load;
  logic [2:0]        o_status;
  entry_t            o_entry;
  logic              o_last;

  // incoming interval with a 33-bit end
  assign new_entry.lo = start_req;
  assign new_entry.hi = {1'b0, start_req} + {1'b0, length};

  assign full     = (count == CNT_W'(DEPTH));
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_xfer  = in_valid && in_ready;

  // head test during the rotation
  assign head_valid = (CNT_W'(step) < count);

  iovq_match u_match (
    .head       (cells[0]),
    .head_valid (head_valid),
    .q_lo       (q_lo),
    .q_hi       (q_hi),
    .mode       (mode),
    .hit        (hit)
  );

  // rotate unless a second match waits on a busy output
  assign adv = (state == S_SCAN) && (!hit || !pend_valid || out_free);

  assign ctl.insert = in_xfer && (kind == KIND_LOAD) && !full;
  assign ctl.rotate = adv;

  // chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count);

    iovq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ[i]),
      .new_entry  (new_entry),
      .prev_entry ((i == 0) ? new_entry : cells[(i + DEPTH - 1) % DEPTH]),
      .prev_g     ((i == 0) ? 1'b0 : g[(i + DEPTH - 1) % DEPTH]),
      .next_entry (cells[(i + 1) % DEPTH]),
      .entry      (cells[i]),
      .g          (g[i])
    );
  end

  // sequencer and output selection
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    o_status   = ST_MATCH;
    o_entry    = '0;
    o_last     = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          case (kind)
            KIND_CLEAR: begin
              out_load = 1'b1;
              o_status = ST_CLEARED;
            end
            KIND_LOAD: begin
              out_load = 1'b1;
              o_status = full ? ST_FULL : ST_LOADED;
            end
            KIND_QUERY: begin
              state_next = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (adv && hit && pend_valid) begin
          out_load = 1'b1;
          o_status = ST_MATCH;
          o_entry  = pend;
          o_last   = 1'b0;
        end
        if (adv && (step == STEP_W'(DEPTH - 1))) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (pend_valid) begin
            o_status = ST_MATCH;
            o_entry  = pend;
          end else begin
            o_status = ST_NO_MATCH;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      step       <= '0;
      mode       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPAN:        mode.span        <= cfg_data;
          CFG_NOT_SPAN:    mode.not_span    <= cfg_data;
          CFG_NOT_SPANNED: mode.not_spanned <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_xfer && (kind == KIND_CLEAR)) begin
        count <= '0;
      end else if (ctl.insert) begin
        count <= count + CNT_W'(1);
      end
      if (in_xfer && (kind == KIND_QUERY)) begin
        step       <= '0;
        pend_valid <= 1'b0;
      end else if (adv) begin
        step <= step + STEP_W'(1);
        if (hit) begin
          pend_valid <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer && (kind == KIND_QUERY)) begin
      q_lo <= new_entry.lo;
      q_hi <= new_entry.hi;
    end
    if (adv && hit) begin
      pend <= cells[0];
    end
    if (out_load) begin
      status      <= o_status;
      match_start <= o_entry.lo;
      match_end   <= o_entry.hi;
      last        <= o_last;
    end
  end

endmodule

// ===== dv/interval_overlap_query_tb.sv =====
// self-checking testbench for the interval overlap query block
`timescale 1ns / 1ps

module interval_overlap_query_tb
  import iovq_pkg::*;
();

  localparam int TABLE_CELLS = DEPTH_DEF;
  localparam int PHASES = 8;
  localparam int FILL_PHASE = 4;
  localparam int HOLD_PHASE = 1;
  localparam int UNUSED_WRITE_PHASE = 3;
  localparam int ITEMS_PER_PHASE = 20;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = TABLE_CELLS + 16;

  // codes that the package leaves out
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  // one result transfer as seen on the output port
  typedef struct {
    logic [2:0]  status;
    logic [31:0] m_start;
    logic [32:0] m_end;
    logic        is_last;
  } result_t;

  // one row of the directed stimulus
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] start;
    logic [31:0] len;
    bit          has_fix;
    logic [2:0]  fix_st;
  } step_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SPAN;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = KIND_CLEAR;
  logic [31:0] start_req = '0;
  logic [31:0] length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] match_start;
  logic [32:0] match_end;
  logic        last;

  interval_overlap_query #(
    .DEPTH(TABLE_CELLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .start_req(start_req),
    .length(length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .match_start(match_start),
    .match_end(match_end),
    .last(last)
  );

  // clock, 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // shadow copy of the interval table and the filter flags
  logic [31:0] tab_lo [TABLE_CELLS];
  logic [32:0] tab_hi [TABLE_CELLS];
  int          tab_count = 0;
  mode_t       mode_now = '0;

  result_t op_results[$];
  result_t awaited_results[$];
  int      mismatches = 0;

  int send_idle_pct = 6;
  int recv_idle_pct = 82;
  int holds_wanted = 0;

  mode_t phase_modes [PHASES] = '{3'b100, 3'b010, 3'b001, 3'b110,
                                  3'b000, 3'b011, 3'b101, 3'b111};

  step_row_t directed_rows [24] = '{
    '{KIND_QUERY,  32'd5,          32'd5,          1'b1, ST_NO_MATCH},
    '{KIND_UNUSED, 32'd7,          32'd7,          1'b1, ST_MATCH},
    '{KIND_LOAD,   32'd100,        32'd50,         1'b1, ST_LOADED},
    '{KIND_LOAD,   32'd0,          32'd0,          1'b1, ST_LOADED},
    '{KIND_LOAD,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, ST_LOADED},
    '{KIND_LOAD,   32'd100,        32'd10,         1'b1, ST_LOADED},
    '{KIND_LOAD,   32'd50,         32'd200,        1'b1, ST_LOADED},
    '{KIND_LOAD,   32'd0,          32'hFFFF_FFFF,  1'b1, ST_LOADED},
    '{KIND_QUERY,  32'd120,        32'd5,          1'b0, ST_MATCH},
    '{KIND_QUERY,  32'd0,          32'd0,          1'b0, ST_MATCH},
    '{KIND_QUERY,  32'd100,        32'd0,          1'b0, ST_MATCH},
    '{KIND_QUERY,  32'hFFFF_FFFE,  32'd2,          1'b0, ST_MATCH},
    '{KIND_QUERY,  32'd0,          32'hFFFF_FFFF,  1'b0, ST_MATCH},
    '{KIND_QUERY,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, ST_MATCH},
    '{KIND_QUERY,  32'd149,        32'd1,          1'b0, ST_MATCH},
    '{KIND_QUERY,  32'd150,        32'd1,          1'b0, ST_MATCH},
    '{KIND_QUERY,  32'd99,         32'd1,          1'b0, ST_MATCH},
    '{KIND_CLEAR,  32'd0,          32'd0,          1'b1, ST_CLEARED},
    '{KIND_QUERY,  32'd0,          32'hFFFF_FFFF,  1'b1, ST_NO_MATCH},
    '{KIND_LOAD,   32'd10,         32'd20,         1'b1, ST_LOADED},
    '{KIND_LOAD,   32'd10,         32'd5,          1'b1, ST_LOADED},
    '{KIND_LOAD,   32'd3,          32'd5,          1'b1, ST_LOADED},
    '{KIND_QUERY,  32'd10,         32'd1,          1'b0, ST_MATCH},
    '{KIND_QUERY,  32'hAAAA_AAAA,  32'h5555_5555,  1'b0, ST_MATCH}
  };

  // apply one operation to the shadow table, results go to op_results
  function automatic void apply_interval_op(input logic [1:0] k, input logic [31:0] s,
                                            input logic [31:0] l);
    logic [32:0] q_hi;
    int          pos;
    bit          covers;
    bit          inner;
    result_t     r;
    q_hi = {1'b0, s} + {1'b0, l};
    op_results.delete();
    case (k)
      KIND_CLEAR: begin
        tab_count = 0;
        r = '{ST_CLEARED, '0, '0, 1'b1};
        op_results = {op_results, r};
      end
      KIND_LOAD: begin
        if (tab_count >= TABLE_CELLS) begin
          r = '{ST_FULL, '0, '0, 1'b1};
          op_results = {op_results, r};
        end else begin
          // stable insertion: go after every entry with the same start
          pos = tab_count;
          while (pos > 0 && tab_lo[pos-1] > s) begin
            tab_lo[pos] = tab_lo[pos-1];
            tab_hi[pos] = tab_hi[pos-1];
            pos--;
          end
          tab_lo[pos] = s;
          tab_hi[pos] = q_hi;
          tab_count++;
          r = '{ST_LOADED, '0, '0, 1'b1};
          op_results = {op_results, r};
        end
      end
      KIND_QUERY: begin
        for (int i = 0; i < tab_count; i++) begin
          covers = (tab_lo[i] <= s) && (q_hi <= tab_hi[i]);
          inner = (s <= tab_lo[i]) && (tab_hi[i] <= q_hi);
          if (!(tab_lo[i] < q_hi && s < tab_hi[i])) continue;
          if (mode_now.span && !covers) continue;
          if (mode_now.not_span && covers) continue;
          if (mode_now.not_spanned && inner) continue;
          r = '{ST_MATCH, tab_lo[i], tab_hi[i], 1'b0};
          op_results = {op_results, r};
        end
        if (op_results.size() == 0) begin
          r = '{ST_NO_MATCH, '0, '0, 1'b1};
          op_results = {op_results, r};
        end else begin
          r = op_results.pop_back();
          r.is_last = 1'b1;
          op_results = {op_results, r};
        end
      end
      default: begin
      end
    endcase
  endfunction

  // mostly near zero so intervals meet, sometimes near the top or anywhere
  function automatic logic [31:0] rand_start();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 2000);
    if (r < 80) return 32'hFFFF_FFFF - $urandom_range(0, 2000);
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 70) return $urandom_range(1, 300);
    if (r < 85) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 1000);
  endfunction

  // query built around a stored interval so the span filters see both outcomes
  function automatic logic [63:0] pick_query();
    int          j;
    logic [32:0] w;
    logic [31:0] lo;
    logic [31:0] s;
    logic [31:0] l;
    if (tab_count == 0 || $urandom_range(0, 99) < 55) return {rand_start(), rand_len()};
    j = $urandom_range(0, tab_count - 1);
    lo = tab_lo[j];
    w = tab_hi[j] - {1'b0, tab_lo[j]};
    case ($urandom_range(0, 3))
      0: begin
        s = lo;
        l = w[31:0];
      end
      1: begin
        s = lo + $urandom_range(0, 20);
        l = $urandom_range(0, 20);
      end
      2: begin
        s = lo - $urandom_range(0, 20);
        l = w[31:0] + 32'd40;
      end
      default: begin
        s = lo - 32'd10;
        l = $urandom_range(5, 30);
      end
    endcase
    return {s, l};
  endfunction

  // offer one item, wait for the transfer, then record what it should cause
  task automatic send_item(input logic [1:0] k, input logic [31:0] s, input logic [31:0] l,
                           input bit has_fix, input logic [2:0] fix_st);
    result_t fixed;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    start_req <= s;
    length <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_interval_op(k, s, l);
    if (has_fix) begin
      if (k != KIND_UNUSED) begin
        fixed = '{fix_st, '0, '0, 1'b1};
        awaited_results = {awaited_results, fixed};
      end
    end else begin
      awaited_results = {awaited_results, op_results};
    end
  endtask

  // drop valid and let the block drain fully
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; the caller lowers the enable after the last one
  task automatic write_reg(input logic [1:0] idx, input logic d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    case (idx)
      CFG_SPAN:        mode_now.span = d;
      CFG_NOT_SPAN:    mode_now.not_span = d;
      CFG_NOT_SPANNED: mode_now.not_spanned = d;
      default: begin
      end
    endcase
  endtask

  // compare one output transfer with the oldest expectation
  task automatic check_transfer();
    result_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: status %0d start %0h end %0h last %0b",
             status, match_start, match_end, last);
      mismatches++;
      return;
    end
    want = awaited_results.pop_front();
    if (status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status);
      mismatches++;
    end
    if (match_start !== want.m_start) begin
      $error("match_start: expected %0h, got %0h", want.m_start, match_start);
      mismatches++;
    end
    if (match_end !== want.m_end) begin
      $error("match_end: expected %0h, got %0h", want.m_end, match_end);
      mismatches++;
    end
    if (last !== want.is_last) begin
      $error("last: expected %0b, got %0b", want.is_last, last);
      mismatches++;
    end
  endtask

  // output side: check transfers, random stalls and a long hold on request
  initial begin : result_side
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_transfer();
      if (holds_wanted != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // input side: reset, directed rows, then random phases under each filter setting
  initial begin : stimulus
    int          r;
    int          counted;
    logic [63:0] q;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].kind, directed_rows[i].start, directed_rows[i].len,
                directed_rows[i].has_fix, directed_rows[i].fix_st);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      write_reg(CFG_SPAN, phase_modes[ph].span);
      write_reg(CFG_NOT_SPAN, phase_modes[ph].not_span);
      write_reg(CFG_NOT_SPANNED, phase_modes[ph].not_spanned);
      if (ph == UNUSED_WRITE_PHASE) write_reg(CFG_UNUSED, 1'b1);
      cfg_we <= 1'b0;

      // idle profile: sender light / receiver heavy, then swapped, then none
      if (ph < 2) begin
        send_idle_pct = 6;
        recv_idle_pct = 82;
      end else if (ph < 5) begin
        send_idle_pct = 82;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == HOLD_PHASE) holds_wanted++;

      // fill the table to the brim, overflow it, then query the full table
      if (ph == FILL_PHASE) begin
        while (tab_count < TABLE_CELLS) send_item(KIND_LOAD, rand_start(), rand_len(),
                                                  1'b0, ST_MATCH);
        repeat (3) send_item(KIND_LOAD, rand_start(), rand_len(), 1'b0, ST_MATCH);
        send_item(KIND_QUERY, 32'd0, 32'hFFFF_FFFF, 1'b0, ST_MATCH);
      end

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_item(KIND_CLEAR, $urandom, $urandom, 1'b0, ST_MATCH);
          counted++;
        end else if (r < 5) begin
          send_item(KIND_UNUSED, $urandom, $urandom, 1'b0, ST_MATCH);
        end else if (r < 45) begin
          send_item(KIND_LOAD, rand_start(), rand_len(), 1'b0, ST_MATCH);
          counted++;
        end else begin
          q = pick_query();
          send_item(KIND_QUERY, q[63:32], q[31:0], 1'b0, ST_MATCH);
          counted++;
        end
      end
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
